>>> hw/rtl/ccp_pkg.sv
`default_nettype none

package ccp_pkg;

   // Parser phases, one-hot.
   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_COUNT_LO = 7'b0000010,
      PH_TAG      = 7'b0000100,
      PH_FIELDS   = 7'b0001000,
      PH_STRING   = 7'b0010000,
      PH_DONE     = 7'b0100000,
      PH_HALT     = 7'b1000000
   } ccp_phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_ENTRY = 2'd0;
   localparam logic [1:0] KIND_UNIT  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_UNKNOWN_TAG = 2'd0;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
   localparam logic [1:0] ERR_MALFORMED   = 2'd2;

   // Constant pool tags.
   localparam logic [7:0] TAG_UTF8          = 8'd1;
   localparam logic [7:0] TAG_INTEGER       = 8'd3;
   localparam logic [7:0] TAG_FLOAT         = 8'd4;
   localparam logic [7:0] TAG_LONG          = 8'd5;
   localparam logic [7:0] TAG_DOUBLE        = 8'd6;
   localparam logic [7:0] TAG_CLASS         = 8'd7;
   localparam logic [7:0] TAG_STRING        = 8'd8;
   localparam logic [7:0] TAG_FIELDREF      = 8'd9;
   localparam logic [7:0] TAG_METHODREF     = 8'd10;
   localparam logic [7:0] TAG_IFACE_METHOD  = 8'd11;
   localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] entry_index;
      logic [3:0]  tag;
      logic [31:0] value_a;
      logic [15:0] value_b;
      logic [1:0]  error_code;
      logic        pool_done;
      logic        last;
   } ccp_result_type;

   // Up to two results caused by one input beat; r0 is delivered first.
   typedef struct packed {
      logic [1:0]     n;
      ccp_result_type r0;
      ccp_result_type r1;
   } ccp_push_type;

   function automatic logic two_fields(input logic [3:0] t);
      logic [7:0] tb;
      tb = {4'h0, t};
      return tb inside {TAG_FIELDREF, TAG_METHODREF, TAG_IFACE_METHOD, TAG_NAME_AND_TYPE};
   endfunction

   function automatic ccp_result_type make_result(
      input logic [1:0]  kind,
      input logic [15:0] index,
      input logic [3:0]  tag,
      input logic [31:0] a,
      input logic [15:0] b,
      input logic [1:0]  err,
      input logic        done,
      input logic        last
   );
      ccp_result_type r;
      r.kind        = kind;
      r.entry_index = index;
      r.tag         = tag;
      r.value_a     = a;
      r.value_b     = b;
      r.error_code  = err;
      r.pool_done   = done;
      r.last        = last;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ccp_decoder.sv
`default_nettype none

module ccp_decoder (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                first_byte,
   output ccp_pkg::ccp_push_type    push
);
   import ccp_pkg::*;

   ccp_phase_type phase_ff, phase_in;
   logic [3:0]  current_tag_ff, current_tag_in;
   logic [2:0]  field_left_ff, field_left_in;
   logic [31:0] field_shift_ff, field_shift_in;
   logic [15:0] first_field_ff, first_field_in;
   logic [15:0] string_left_ff, string_left_in;
   logic [15:0] entry_ff, entry_in;
   logic [15:0] pool_count_ff, pool_count_in;
   logic [15:0] unit_count_ff, unit_count_in;
   logic [15:0] partial_ff, partial_in;
   logic [1:0]  seq_left_ff, seq_left_in;

   logic [16:0] next_entry;
   logic        rec_done;

   assign next_entry = {1'b0, entry_ff} + 17'd1;
   assign rec_done   = next_entry >= {1'b0, pool_count_ff};

   always_comb begin
      logic [31:0] fs;
      logic [2:0]  fbl;
      logic [15:0] sbl;
      logic [15:0] pu;
      logic [1:0]  sl;
      logic        unit;
      logic        bad;
      logic        do_record;
      logic        rec_slot;
      logic [31:0] rec_a;
      logic [15:0] rec_b;
      ccp_result_type rec;

      phase_in       = phase_ff;
      current_tag_in = current_tag_ff;
      field_left_in  = field_left_ff;
      field_shift_in = field_shift_ff;
      first_field_in = first_field_ff;
      string_left_in = string_left_ff;
      entry_in       = entry_ff;
      pool_count_in  = pool_count_ff;
      unit_count_in  = unit_count_ff;
      partial_in     = partial_ff;
      seq_left_in    = seq_left_ff;
      push           = '0;
      fs             = '0;
      fbl            = '0;
      sbl            = '0;
      pu             = partial_ff;
      sl             = seq_left_ff;
      unit           = 1'b0;
      bad            = 1'b0;
      do_record      = 1'b0;
      rec_slot       = 1'b0;
      rec_a          = '0;
      rec_b          = '0;
      rec            = '0;

      if (accept) begin
         if (first_byte) begin
            // Restart: clear everything and take this byte as the count's high half.
            current_tag_in = '0;
            field_left_in  = '0;
            field_shift_in = '0;
            first_field_in = '0;
            string_left_in = '0;
            entry_in       = '0;
            unit_count_in  = '0;
            partial_in     = '0;
            seq_left_in    = '0;
            pool_count_in  = {data_byte, 8'h00};
            phase_in       = PH_COUNT_LO;
         end else begin
            case (phase_ff)
               PH_COUNT_LO: begin
                  pool_count_in = {pool_count_ff[15:8], data_byte};
                  entry_in      = 16'd1;
                  phase_in      = (pool_count_in <= 16'd1) ? PH_DONE : PH_TAG;
               end
               PH_TAG: begin
                  current_tag_in = data_byte[3:0];
                  field_shift_in = '0;
                  first_field_in = '0;
                  if (data_byte inside {TAG_FLOAT, TAG_LONG, TAG_DOUBLE}) begin
                     push.n   = 2'd1;
                     push.r0  = make_result(KIND_ERROR, entry_ff, current_tag_in,
                                            {24'h0, data_byte}, 16'h0, ERR_UNSUPPORTED,
                                            1'b0, 1'b0);
                     phase_in = PH_HALT;
                  end else if (data_byte inside {TAG_CLASS, TAG_STRING, TAG_UTF8}) begin
                     field_left_in = 3'd2;
                     phase_in      = PH_FIELDS;
                  end else if (data_byte inside {TAG_INTEGER, TAG_FIELDREF, TAG_METHODREF,
                                                 TAG_IFACE_METHOD, TAG_NAME_AND_TYPE}) begin
                     field_left_in = 3'd4;
                     phase_in      = PH_FIELDS;
                  end else begin
                     push.n   = 2'd1;
                     push.r0  = make_result(KIND_ERROR, entry_ff, current_tag_in,
                                            {24'h0, data_byte}, 16'h0, ERR_UNKNOWN_TAG,
                                            1'b0, 1'b0);
                     phase_in = PH_HALT;
                  end
               end
               PH_FIELDS: begin
                  fs  = {field_shift_ff[23:0], data_byte};
                  fbl = field_left_ff - 3'd1;
                  field_left_in = fbl;
                  // Two-index entries park the first index once its two bytes are in.
                  if (fbl == 3'd2 && two_fields(current_tag_ff)) begin
                     first_field_in = fs[15:0];
                     fs             = '0;
                  end
                  field_shift_in = fs;
                  if (fbl == 3'd0) begin
                     if ({4'h0, current_tag_ff} == TAG_UTF8) begin
                        string_left_in = fs[15:0];
                        unit_count_in  = '0;
                        partial_in     = '0;
                        seq_left_in    = '0;
                        if (fs[15:0] == 16'd0) begin
                           do_record = 1'b1;
                        end else begin
                           phase_in = PH_STRING;
                        end
                     end else if ({4'h0, current_tag_ff} == TAG_INTEGER) begin
                        do_record = 1'b1;
                        rec_a     = fs;
                     end else if (two_fields(current_tag_ff)) begin
                        do_record = 1'b1;
                        rec_a     = {16'h0, first_field_ff};
                        rec_b     = fs[15:0];
                     end else begin
                        do_record = 1'b1;
                        rec_a     = {16'h0, fs[15:0]};
                     end
                  end
               end
               PH_STRING: begin
                  sbl = string_left_ff - 16'd1;
                  string_left_in = sbl;
                  if (seq_left_ff == 2'd0) begin
                     if (data_byte[7]) begin
                        if (data_byte[7:5] == 3'b110) begin
                           pu = {11'h0, data_byte[4:0]};
                           sl = 2'd1;
                        end else if (data_byte[7:4] == 4'b1110) begin
                           pu = {12'h0, data_byte[3:0]};
                           sl = 2'd2;
                        end else begin
                           bad = 1'b1;
                        end
                     end else if (data_byte == 8'h00) begin
                        bad = 1'b1;
                     end else begin
                        pu   = {8'h0, data_byte};
                        unit = 1'b1;
                     end
                  end else begin
                     if (data_byte[7:6] != 2'b10) begin
                        bad = 1'b1;
                     end else begin
                        pu   = {partial_ff[9:0], data_byte[5:0]};
                        sl   = seq_left_ff - 2'd1;
                        unit = (sl == 2'd0);
                     end
                  end
                  // A multi-byte sequence may not run past the declared length.
                  if (!bad && sbl == 16'd0 && sl != 2'd0) begin
                     bad = 1'b1;
                  end
                  partial_in  = pu;
                  seq_left_in = sl;
                  if (bad) begin
                     push.n   = 2'd1;
                     push.r0  = make_result(KIND_ERROR, entry_ff, current_tag_in,
                                            {24'h0, data_byte}, 16'h0, ERR_MALFORMED,
                                            1'b0, 1'b0);
                     phase_in = PH_HALT;
                  end else begin
                     if (unit) begin
                        push.n        = 2'd1;
                        push.r0       = make_result(KIND_UNIT, entry_ff, current_tag_in,
                                                    {16'h0, pu}, 16'h0, ERR_UNKNOWN_TAG,
                                                    1'b0, sbl != 16'd0);
                        unit_count_in = unit_count_ff + 16'd1;
                     end
                     if (sbl == 16'd0) begin
                        do_record = 1'b1;
                        rec_slot  = unit;
                        rec_a     = {16'h0, unit_count_in};
                     end
                  end
               end
               default: begin
                  // Idle, done and halted ignore bytes until a restart.
               end
            endcase

            if (do_record) begin
               rec = make_result(KIND_ENTRY, entry_ff, current_tag_in, rec_a, rec_b,
                                 ERR_UNKNOWN_TAG, rec_done, 1'b1);
               if (rec_slot) begin
                  push.r1 = rec;
                  push.n  = 2'd2;
               end else begin
                  push.r0 = rec;
                  push.n  = 2'd1;
               end
               if (rec_done) begin
                  phase_in = PH_DONE;
               end else begin
                  entry_in = next_entry[15:0];
                  phase_in = PH_TAG;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         current_tag_ff <= '0;
         field_left_ff  <= '0;
         field_shift_ff <= '0;
         first_field_ff <= '0;
         string_left_ff <= '0;
         entry_ff       <= '0;
         pool_count_ff  <= '0;
         unit_count_ff  <= '0;
         partial_ff     <= '0;
         seq_left_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         current_tag_ff <= current_tag_in;
         field_left_ff  <= field_left_in;
         field_shift_ff <= field_shift_in;
         first_field_ff <= first_field_in;
         string_left_ff <= string_left_in;
         entry_ff       <= entry_in;
         pool_count_ff  <= pool_count_in;
         unit_count_ff  <= unit_count_in;
         partial_ff     <= partial_in;
         seq_left_ff    <= seq_left_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ccp_rsp_fifo.sv
`default_nettype none

module ccp_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ccp_pkg::ccp_push_type      push,
   output logic                       space,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ccp_pkg::ccp_result_type    rsp
);
   import ccp_pkg::*;

   ccp_result_type          mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]    wptr_ff, wptr_in;
   logic [RSP_PTR_W-1:0]    rptr_ff, rptr_in;
   logic [RSP_CNT_W-1:0]    count_ff, count_in;
   logic [RSP_PTR_W-1:0]    wptr_next;
   logic                    pop;

   // Room for the two results that one beat can cause.
   assign space     = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp       = mem[rptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wptr_next = RSP_PTR_W'(wptr_ff + 1'b1);

   always_comb begin
      wptr_in  = RSP_PTR_W'(wptr_ff + RSP_PTR_W'(push.n));
      rptr_in  = pop ? RSP_PTR_W'(rptr_ff + 1'b1) : rptr_ff;
      count_in = RSP_CNT_W'(count_ff + RSP_CNT_W'(push.n) - RSP_CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem[wptr_ff] <= push.r0;
      end
      if (push.n == 2'd2) begin
         mem[wptr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/class_constant_pool_parser.sv
// Class-file constant pool parser.
//
// The request channel carries one beat per stream byte: req_data_byte and
// req_first_byte, which marks the high byte of the entry count and restarts
// the parser from any phase. The response channel delivers one result per
// beat: entry records, decoded Utf8 code units and errors; rsp_last marks the
// final result caused by a given input byte, and an error leaves it low.
//
// Each accepted byte is decoded in the cycle it is taken, and its results are
// written into a four-entry result queue, so a result can appear on the
// response channel in the cycle after its byte is accepted. A byte that
// finishes a code unit and its string at once causes two results, which
// leave on the response side one at a time.
//
// req_ready is high while the queue has room for two results, so the block
// keeps taking bytes while earlier results wait for the receiver. When the
// receiver stalls, the queue fills and req_ready drops until beats are taken.
// Reset empties the queue and returns the parser to waiting for a first byte.
`default_nettype none

module class_constant_pool_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_entry_index,
   output logic [3:0]       rsp_tag,
   output logic [31:0]      rsp_value_a,
   output logic [15:0]      rsp_value_b,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_pool_done,
   output logic             rsp_last
);
   import ccp_pkg::*;

   ccp_push_type   push;
   ccp_result_type rsp;
   logic           accept;

   // A byte is taken only when the queue can absorb everything it may cause.
   assign accept = req_valid && req_ready;

   ccp_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .push       (push)
   );

   ccp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // The head of the queue drives the response payload directly.
   assign rsp_kind        = rsp.kind;
   assign rsp_entry_index = rsp.entry_index;
   assign rsp_tag         = rsp.tag;
   assign rsp_value_a     = rsp.value_a;
   assign rsp_value_b     = rsp.value_b;
   assign rsp_error_code  = rsp.error_code;
   assign rsp_pool_done   = rsp.pool_done;
   assign rsp_last        = rsp.last;

endmodule

`default_nettype wire

>>> hw/rtl/ccp_checker.sv
`default_nettype none

module ccp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [31:0] rsp_value_a,
   input wire logic [15:0] rsp_value_b,
   input wire logic [1:0]  rsp_error_code,
   input wire logic        rsp_pool_done,
   input wire logic        rsp_last
);
   import ccp_pkg::*;

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled result stays valid and keeps its kind, values and last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value_a)
         && $stable(rsp_value_b) && $stable(rsp_last))
      else $error("stalled response changed");

   // Only error results carry a nonzero error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == ERR_UNKNOWN_TAG)
      else $error("error code on a non-error result");

   // Code units and errors never close the pool and have no second field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_UNIT || rsp_kind == KIND_ERROR)
         |-> !rsp_pool_done && rsp_value_b == 16'h0)
      else $error("unit or error result with record fields");

   // An error leaves the last flag low and carries only the offending byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> !rsp_last && rsp_value_a[31:8] == 24'h0)
      else $error("malformed error result");

endmodule

bind class_constant_pool_parser ccp_checker u_ccp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_value_a    (rsp_value_a),
   .rsp_value_b    (rsp_value_b),
   .rsp_error_code (rsp_error_code),
   .rsp_pool_done  (rsp_pool_done),
   .rsp_last       (rsp_last)
);

`default_nettype wire
